### rtl/cbf_pkg.sv
// Package for the camera basis block: widths, the queue entry type and the
// rounding helper. No dependencies.
package cbf_pkg;

    localparam int FWD_W     = 16;
    localparam int OUT_W     = 16;
    localparam int C_W       = 18;
    localparam int EPS_W     = 12;
    localparam int EPS_RESET = 1;
    localparam int QDEPTH    = 4;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam logic REG_EPS = 1'b0;

    typedef struct packed {
        logic signed [C_W-1:0]   cx;
        logic signed [C_W-1:0]   cy;
        logic signed [C_W-1:0]   cz;
        logic signed [FWD_W-1:0] fx;
        logic signed [FWD_W-1:0] fy;
        logic signed [FWD_W-1:0] fz;
        logic                    use_z;
    } t_item;

    // Rounds a Q.26 product difference to Q.12 units, half toward +infinity.
    function automatic logic signed [C_W-1:0] round_q12(input logic signed [32:0] p);
        logic signed [33:0] b;
        b = 34'(p) + 34'sd8192;
        return C_W'(b >>> 14);
    endfunction

endpackage

### rtl/cbf_if.sv
// Channel interfaces for the camera basis block.
// Depends on cbf_pkg for field widths.
interface cbf_in_if import cbf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [FWD_W-1:0] fwd_x;
    logic signed [FWD_W-1:0] fwd_y;
    logic signed [FWD_W-1:0] fwd_z;
    modport source (output valid, fwd_x, fwd_y, fwd_z, input ready);
    modport sink (input valid, fwd_x, fwd_y, fwd_z, output ready);
endinterface

interface cbf_out_if import cbf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] cam_up_x;
    logic signed [OUT_W-1:0] cam_up_y;
    logic signed [OUT_W-1:0] cam_up_z;
    logic                    up_is_z;
    logic                    degenerate;
    modport source (output valid, right_x, right_y, right_z, cam_up_x, cam_up_y,
                    cam_up_z, up_is_z, degenerate, input ready);
    modport sink (input valid, right_x, right_y, right_z, cam_up_x, cam_up_y,
                  cam_up_z, up_is_z, degenerate, output ready);
endinterface

### rtl/cbf_front.sv
// Front end: accepts forward vectors, picks the world up axis and forms the
// first cross product. Depends on cbf_pkg.
module cbf_front import cbf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [EPS_W-1:0]        i_eps,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  logic signed [FWD_W-1:0] i_fx,
    input  logic signed [FWD_W-1:0] i_fy,
    input  logic signed [FWD_W-1:0] i_fz,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output t_item                   o_item
);
    logic               r_vld;
    t_item              r_item;
    t_item              n_item;
    logic [FWD_W:0]     mx;
    logic [FWD_W:0]     mz;
    logic               use_z;

    always_comb begin
        mx = i_fx[FWD_W-1] ? (FWD_W+1)'(-$signed({i_fx[FWD_W-1], i_fx}))
                           : (FWD_W+1)'(i_fx);
        mz = i_fz[FWD_W-1] ? (FWD_W+1)'(-$signed({i_fz[FWD_W-1], i_fz}))
                           : (FWD_W+1)'(i_fz);
        use_z = (i_eps != '0) && (mx < (FWD_W+1)'(i_eps)) && (mz < (FWD_W+1)'(i_eps));
        n_item.fx = i_fx;
        n_item.fy = i_fy;
        n_item.fz = i_fz;
        n_item.use_z = use_z;
        if (use_z) begin
            n_item.cx = -C_W'(i_fy);
            n_item.cy = C_W'(i_fx);
            n_item.cz = '0;
        end else begin
            n_item.cx = C_W'(i_fz);
            n_item.cy = '0;
            n_item.cz = -C_W'(i_fx);
        end
    end

    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= n_item;
        end
    end
endmodule

### rtl/cbf_fifo.sv
// Short queue between the front end and the datapath.
// Depends on cbf_pkg for the entry type.
module cbf_fifo import cbf_pkg::*; #(
    parameter int DEPTH = QDEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item         r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_cnt;
    logic          wr;
    logic          rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rptr];
    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end
endmodule

### rtl/cbf_norm.sv
// Pipelined vector normalizer to Q1.14 with exact round-to-nearest, one result
// bit per stage from shift-and-add residuals. Depends on cbf_pkg.
module cbf_norm import cbf_pkg::*; #(
    parameter int SB_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [2:0][C_W-1:0]         i_c,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_vld,
    output logic [2:0][OUT_W-1:0]       o_comp,
    output logic                        o_zero,
    output logic [SB_W-1:0]             o_sb
);
    localparam int NS = 15;
    localparam int MW = C_W;
    localparam int QW = 2 * MW;
    localparam int SW = QW + 2;
    localparam int RW = 68;

    logic                   a_vld;
    logic [QW-1:0]          a_sq  [0:2];
    logic                   a_sg  [0:2];
    logic [SB_W-1:0]        a_sb;

    logic                   p_vld [0:NS];
    logic signed [RW-1:0]   p_rem [0:NS][0:2];
    logic signed [RW-1:0]   p_w   [0:NS][0:2];
    logic [NS-1:0]          p_lo  [0:NS][0:2];
    logic                   p_sg  [0:NS][0:2];
    logic signed [RW-1:0]   p_s   [0:NS];
    logic                   p_z   [0:NS];
    logic [SB_W-1:0]        p_sb  [0:NS];

    logic signed [RW-1:0]   n_rem [1:NS][0:2];
    logic signed [RW-1:0]   n_w   [1:NS][0:2];
    logic [NS-1:0]          n_lo  [1:NS][0:2];
    logic [SW-1:0]          s_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            a_vld <= 1'b0;
            for (int j = 0; j <= NS; j++) begin
                p_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            a_vld    <= i_vld;
            p_vld[0] <= a_vld;
            for (int j = 1; j <= NS; j++) begin
                p_vld[j] <= p_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                a_sg[i] <= i_c[i][C_W-1];
            end
            a_sb <= i_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                a_sq[i] <= QW'($signed(i_c[i])) * QW'($signed(i_c[i]));
            end
        end
    end

    assign s_sum = SW'(a_sq[0]) + SW'(a_sq[1]) + SW'(a_sq[2]);

    always_comb begin
        for (int j = 1; j <= NS; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_rem[j][i] = p_rem[j-1][i] - (p_w[j-1][i] <<< (NS - j + 2))
                              - (p_s[j-1] <<< (2 * (NS - j) + 2));
                if (!n_rem[j][i][RW-1]) begin
                    n_w[j][i]  = p_w[j-1][i] + (p_s[j-1] <<< (NS - j + 1));
                    n_lo[j][i] = p_lo[j-1][i] | (NS'(1) << (NS - j));
                end else begin
                    n_rem[j][i] = p_rem[j-1][i];
                    n_w[j][i]   = p_w[j-1][i];
                    n_lo[j][i]  = p_lo[j-1][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            p_s[0]  <= RW'(s_sum);
            p_z[0]  <= (s_sum == '0);
            p_sb[0] <= a_sb;
            for (int i = 0; i < 3; i++) begin
                p_rem[0][i] <= (RW'(a_sq[i]) <<< 30) - RW'(s_sum);
                p_w[0][i]   <= -RW'(s_sum);
                p_lo[0][i]  <= '0;
                p_sg[0][i]  <= a_sg[i];
            end
            for (int j = 1; j <= NS; j++) begin
                p_s[j]  <= p_s[j-1];
                p_z[j]  <= p_z[j-1];
                p_sb[j] <= p_sb[j-1];
                for (int i = 0; i < 3; i++) begin
                    p_rem[j][i] <= n_rem[j][i];
                    p_w[j][i]   <= n_w[j][i];
                    p_lo[j][i]  <= n_lo[j][i];
                    p_sg[j][i]  <= p_sg[j-1][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (p_z[NS]) begin
                o_comp[i] = '0;
            end else if (p_sg[NS][i]) begin
                o_comp[i] = -OUT_W'(p_lo[NS][i]);
            end else begin
                o_comp[i] = OUT_W'(p_lo[NS][i]);
            end
        end
    end

    assign o_vld  = p_vld[NS];
    assign o_zero = p_z[NS];
    assign o_sb   = p_sb[NS];
endmodule

### rtl/cbf_back.sv
// Back end: normalizes right, forms forward x right, normalizes camera up.
// Depends on cbf_pkg and cbf_norm.
module cbf_back import cbf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  t_item                    i_item,
    output logic                     o_pop,
    output logic                     o_vld,
    input  logic                     i_rdy,
    output logic [2:0][OUT_W-1:0]    o_right,
    output logic [2:0][OUT_W-1:0]    o_up,
    output logic                     o_up_is_z,
    output logic                     o_degen
);
    localparam int SB1 = 3 * FWD_W + 1;
    localparam int SB2 = 3 * OUT_W + 2;

    logic                    adv;
    logic                    n1_vld;
    logic [2:0][OUT_W-1:0]   n1_r;
    logic                    n1_zero;
    logic [SB1-1:0]          n1_sb;
    logic                    r_pvld;
    logic [2:0][C_W-1:0]     r_pc;
    logic [SB2-1:0]          r_psb;
    logic [SB2-1:0]          n2_sb;
    logic                    n2_zero;
    logic signed [FWD_W-1:0] fx;
    logic signed [FWD_W-1:0] fy;
    logic signed [FWD_W-1:0] fz;
    logic signed [OUT_W-1:0] rx;
    logic signed [OUT_W-1:0] ry;
    logic signed [OUT_W-1:0] rz;

    assign adv   = !o_vld || i_rdy;
    assign o_pop = adv && !i_empty;

    cbf_norm #(.SB_W(SB1)) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (!i_empty),
        .i_c     ({i_item.cz, i_item.cy, i_item.cx}),
        .i_sb    ({i_item.use_z, i_item.fz, i_item.fy, i_item.fx}),
        .o_vld   (n1_vld),
        .o_comp  (n1_r),
        .o_zero  (n1_zero),
        .o_sb    (n1_sb)
    );

    assign fx = n1_sb[FWD_W-1:0];
    assign fy = n1_sb[2*FWD_W-1:FWD_W];
    assign fz = n1_sb[3*FWD_W-1:2*FWD_W];
    assign rx = n1_r[0];
    assign ry = n1_r[1];
    assign rz = n1_r[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (adv) begin
            r_pvld <= n1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pc[0] <= round_q12(33'(fy) * 33'(rz) - 33'(fz) * 33'(ry));
            r_pc[1] <= round_q12(33'(fz) * 33'(rx) - 33'(fx) * 33'(rz));
            r_pc[2] <= round_q12(33'(fx) * 33'(ry) - 33'(fy) * 33'(rx));
            r_psb   <= {n1_zero, n1_sb[SB1-1], n1_r};
        end
    end

    cbf_norm #(.SB_W(SB2)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_pvld),
        .i_c     (r_pc),
        .i_sb    (r_psb),
        .o_vld   (o_vld),
        .o_comp  (o_up),
        .o_zero  (n2_zero),
        .o_sb    (n2_sb)
    );

    assign o_right   = n2_sb[3*OUT_W-1:0];
    assign o_up_is_z = n2_sb[3*OUT_W];
    assign o_degen   = n2_sb[3*OUT_W+1] || n2_zero;
endmodule

### rtl/camera_basis_from_forward.sv
// Camera basis from a forward vector: right and camera up in Q1.14.
// Throughput is one transaction per cycle while o_out.ready is high; the two
// 17-stage normalizers each use a one-bit-per-stage
// root search. Synchronous active-low reset clears all valid state and sets
// the threshold register to 1. Depends on cbf_pkg, cbf_if and the cbf modules.
module camera_basis_from_forward import cbf_pkg::*; #(
    parameter int QUEUE_DEPTH = QDEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbf_in_if.sink            i_in,
    cbf_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    logic [EPS_W-1:0]      r_eps;
    logic                  f_vld;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    t_item                 f_item;
    t_item                 q_item;
    logic [2:0][OUT_W-1:0] right;
    logic [2:0][OUT_W-1:0] up;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EPS) ? APB_DW'(r_eps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(EPS_RESET);
        end else if (psel && penable && pwrite && paddr[2] == REG_EPS) begin
            r_eps <= pwdata[EPS_W-1:0];
        end
    end

    cbf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_eps   (r_eps),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_fx    (i_in.fwd_x),
        .i_fy    (i_in.fwd_y),
        .i_fz    (i_in.fwd_z),
        .o_vld   (f_vld),
        .i_rdy   (!q_full),
        .o_item  (f_item)
    );

    cbf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    cbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .o_vld     (o_out.valid),
        .i_rdy     (o_out.ready),
        .o_right   (right),
        .o_up      (up),
        .o_up_is_z (o_out.up_is_z),
        .o_degen   (o_out.degenerate)
    );

    assign o_out.right_x  = right[0];
    assign o_out.right_y  = right[1];
    assign o_out.right_z  = right[2];
    assign o_out.cam_up_x = up[0];
    assign o_out.cam_up_y = up[1];
    assign o_out.cam_up_z = up[2];
endmodule

### tb/tb_camera_basis_from_forward.sv
// Testbench for camera_basis_from_forward: drives forward vectors and APB writes
// of the parallel threshold, predicts each camera basis and checks every result.
// Depends on cbf_pkg, cbf_if and the block's RTL.
`timescale 1ns / 100ps

module tb_camera_basis_from_forward;
    import cbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        logic signed [15:0] rx, ry, rz, ux, uy, uz;
        logic               up_z, degen;
    } t_basis;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    cbf_in_if  in_ch ();
    cbf_out_if out_ch ();

    camera_basis_from_forward u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    t_basis      basis_q[$];
    logic [11:0] eps_reg = 12'd1;
    int          n_errors = 0;
    int          idle_cycles = 0;
    bit          sink_stall_on = 1'b1;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.fwd_x = '0;
        in_ch.fwd_y = '0;
        in_ch.fwd_z = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Each component becomes 16384*c/|c| rounded to nearest, found by bisection.
    function automatic bit unit_q14(input longint c[3], output longint r[3]);
        longint unsigned s, m, tgt, lo, hi, mid, t;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = abs64(c[i]);
            s += m * m;
        end
        if (s == 0) begin
            r = '{0, 0, 0};
            return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            m = abs64(c[i]);
            tgt = (m * m) << 30;
            lo = 0;
            hi = 16384;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                t = 2 * mid - 1;
                if (t * t * s <= tgt) lo = mid;
                else hi = mid - 1;
            end
            r[i] = c[i] < 0 ? -longint'(lo) : longint'(lo);
        end
        return 1'b1;
    endfunction

    function automatic longint to_q12_half_up(longint p);
        return (p + 8192) >>> 14;
    endfunction

    function automatic t_basis camera_basis(logic signed [15:0] fx, fy, fz);
        t_basis b;
        longint x, y, z, e;
        longint c[3], r[3], u[3];
        bit ok_r, ok_u;
        x = fx;
        y = fy;
        z = fz;
        e = eps_reg;
        b.up_z = (abs64(z) < e) && (e > 0) && (abs64(x) < e);
        if (b.up_z) c = '{-y, x, 0};
        else c = '{z, 0, -x};
        ok_r = unit_q14(c, r);
        c[0] = to_q12_half_up(y * r[2] - z * r[1]);
        c[1] = to_q12_half_up(z * r[0] - x * r[2]);
        c[2] = to_q12_half_up(x * r[1] - y * r[0]);
        ok_u = unit_q14(c, u);
        b.rx = r[0]; b.ry = r[1]; b.rz = r[2];
        b.ux = u[0]; b.uy = u[1]; b.uz = u[2];
        b.degen = !(ok_r && ok_u);
        return b;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic send_forward(logic signed [15:0] fx, fy, fz);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.fwd_x <= fx;
        in_ch.fwd_y <= fy;
        in_ch.fwd_z <= fz;
        do @(posedge i_clk); while (!in_ch.ready);
        basis_q.push_back(camera_basis(fx, fy, fz));
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (basis_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [11:0] v);
        go_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4 * REG_EPS;
        pwdata <= {20'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        eps_reg = v;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_small(int lim);
        return 16'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    task automatic test_directed();
        send_forward(16'sd0, 16'sd0, 16'sd0);
        send_forward(16'sd0, 16'sd4096, 16'sd0);
        send_forward(16'sd0, -16'sd4096, 16'sd0);
        send_forward(16'sd0, 16'sd0, 16'sd4096);
        send_forward(16'sd4096, 16'sd0, 16'sd0);
        send_forward(-16'sd32768, -16'sd32768, -16'sd32768);
        send_forward(16'sd32767, 16'sd32767, 16'sd32767);
        send_forward(-16'sd32768, 16'sd32767, 16'sd0);
        send_forward(16'sd1, 16'sd0, 16'sd0);
        send_forward(16'sd0, 16'sd0, -16'sd1);
        send_forward(16'sd1, 16'sd1, 16'sd1);
        send_forward(-16'sd1, 16'sd32767, 16'sd1);
        send_forward(16'sd3, -16'sd5, 16'sd7);
    endtask

    task automatic test_threshold_extremes();
        write_eps(12'd0);
        send_forward(16'sd0, 16'sd4096, 16'sd0);
        send_forward(16'sd0, 16'sd0, 16'sd0);
        write_eps(12'd4095);
        send_forward(16'sd4094, 16'sd100, -16'sd4094);
        send_forward(16'sd4095, 16'sd100, 16'sd0);
        send_forward(16'sd0, 16'sd0, 16'sd0);
        send_forward(16'sd5, 16'sd0, 16'sd3);
        send_forward(-16'sd32768, 16'sd0, 16'sd0);
        write_eps(12'd16);
        send_forward(16'sd15, 16'sd4096, -16'sd15);
        send_forward(16'sd16, 16'sd4096, 16'sd0);
    endtask

    task automatic test_random(int n);
        logic signed [15:0] fx, fy, fz;
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            fy = 16'($urandom);
            if (mode < 4) begin
                fx = 16'($urandom);
                fz = 16'($urandom);
            end else if (mode < 8) begin
                fx = rand_small(int'(eps_reg) + 2);
                fz = rand_small(int'(eps_reg) + 2);
            end else begin
                fx = rand_small(3);
                fz = rand_small(3);
                fy = rand_small(3);
            end
            send_forward(fx, fy, fz);
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_stall_on && $urandom_range(0, 99) < 30) out_ch.ready <= 1'b0;
        else out_ch.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_basis w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (basis_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                w = basis_q.pop_front();
                if (out_ch.right_x !== w.rx) report_mismatch("right_x", out_ch.right_x, w.rx);
                if (out_ch.right_y !== w.ry) report_mismatch("right_y", out_ch.right_y, w.ry);
                if (out_ch.right_z !== w.rz) report_mismatch("right_z", out_ch.right_z, w.rz);
                if (out_ch.cam_up_x !== w.ux) report_mismatch("cam_up_x", out_ch.cam_up_x, w.ux);
                if (out_ch.cam_up_y !== w.uy) report_mismatch("cam_up_y", out_ch.cam_up_y, w.uy);
                if (out_ch.cam_up_z !== w.uz) report_mismatch("cam_up_z", out_ch.cam_up_z, w.uz);
                if (out_ch.up_is_z !== w.up_z) report_mismatch("up_is_z", out_ch.up_is_z, w.up_z);
                if (out_ch.degenerate !== w.degen)
                    report_mismatch("degenerate", out_ch.degenerate, w.degen);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel
                || (!in_ch.valid && basis_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_camera_basis_from_forward NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_threshold_extremes();
        write_eps(12'd1);
        test_random(350);
        write_eps(12'd200);
        test_random(350);
        sink_stall_on = 1'b0;
        write_eps(12'($urandom));
        test_random(325);
        sink_stall_on = 1'b1;
        go_idle();
        if (n_errors == 0) $display("tb_camera_basis_from_forward OK");
        else $display("tb_camera_basis_from_forward NOT OK");
        $finish;
    end

endmodule

### camera_basis_from_forward.f
rtl/cbf_pkg.sv
rtl/cbf_if.sv
rtl/cbf_front.sv
rtl/cbf_fifo.sv
rtl/cbf_norm.sv
rtl/cbf_back.sv
rtl/camera_basis_from_forward.sv
tb/tb_camera_basis_from_forward.sv
